/* rtl/mss_pkg.sv */
// mss_pkg: shared constants, widths and structs of the sponge distance pipeline
// used by mss_front, mss_isqrt and menger_sponge_distance; no dependencies
package mss_pkg;

   localparam int MAX_ITERATIONS = 6;
   localparam int FRAC_BITS      = 24;

   localparam int COORD_W     = 32;
   localparam int DIST_W      = 32;
   localparam int COUNT_W     = 3;
   localparam int COUNT_RESET = 3;

   localparam int ONE = 1 << FRAC_BITS;

   // box distance path
   localparam int X_W    = COORD_W - 1;      // positive excess over one
   localparam int SQ_W   = 2 * X_W;
   localparam int RAD_W  = 2 * COORD_W;      // sum of three squares
   localparam int ROOT_W = RAD_W / 2;
   localparam int REM_W  = ROOT_W + 2;
   localparam int M_W    = FRAC_BITS + 2;    // inner maximum, in [-one, 0]

   // refinement lanes
   localparam int SCALE_W     = 12;          // holds 3^7
   localparam int LANE_W      = FRAC_BITS + 2;
   localparam int C_W         = FRAC_BITS + 3;
   localparam int RECIP_SHIFT = 32;
   localparam int RECIP_W     = 32;

   localparam int FRONT_STAGES = 5;
   localparam int D_W          = ROOT_W + 2;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      logic signed [M_W-1:0] m;
      logic signed [C_W-1:0] cmax;
      logic                  has;
   } side_type;

   typedef struct packed {
      logic [RAD_W-1:0] radicand;
      side_type         side;
   } front_type;

endpackage

/* rtl/mss_front.sv */
// mss_front: box excess, squares and sum, plus one fold/cross/divide lane per iteration
// depends on mss_pkg; five register stages
module mss_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  logic                         in_valid,
   input  mss_pkg::coord_type           pos [3],
   input  logic [mss_pkg::COUNT_W-1:0]  count,
   output logic                         out_valid,
   output mss_pkg::front_type           out_data
);

   localparam int FB      = mss_pkg::FRAC_BITS;
   localparam int CW      = mss_pkg::COORD_W;
   localparam int PROD1_W = FB + 1 + mss_pkg::SCALE_W;
   localparam int PROD3_W = mss_pkg::LANE_W + mss_pkg::RECIP_W;

   logic [mss_pkg::FRONT_STAGES-1:0] vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[mss_pkg::FRONT_STAGES-2:0], in_valid};
      end
   end

   // ---------------- box distance ----------------
   logic [CW-1:0]                mag [3];
   logic signed [CW:0]           e [3];
   logic signed [CW:0]           emax;
   logic [mss_pkg::X_W-1:0]      x_in [3];
   logic signed [mss_pkg::M_W-1:0] m_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag[i]  = pos[i][CW-1] ? (~pos[i] + 1'b1) : pos[i];
         e[i]    = $signed({1'b0, mag[i]}) - $signed((CW+1)'(mss_pkg::ONE));
         x_in[i] = e[i][CW] ? '0 : e[i][mss_pkg::X_W-1:0];
      end
      emax = e[0];
      if (e[1] > emax) emax = e[1];
      if (e[2] > emax) emax = e[2];
      m_in = emax[CW] ? mss_pkg::M_W'(emax) : '0;
   end

   logic [mss_pkg::X_W-1:0]        x1_ff [3];
   logic [mss_pkg::SQ_W-1:0]       sq2_ff [3];
   logic [mss_pkg::RAD_W-1:0]      part3_ff, sq3_ff, sum4_ff, sum5_ff;
   logic signed [mss_pkg::M_W-1:0] m1_ff, m2_ff, m3_ff, m4_ff, m5_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         x1_ff <= x_in;
         m1_ff <= m_in;
         for (int i = 0; i < 3; i++) begin
            sq2_ff[i] <= mss_pkg::SQ_W'(x1_ff[i]) * mss_pkg::SQ_W'(x1_ff[i]);
         end
         m2_ff    <= m1_ff;
         part3_ff <= mss_pkg::RAD_W'(sq2_ff[0]) + mss_pkg::RAD_W'(sq2_ff[1]);
         sq3_ff   <= mss_pkg::RAD_W'(sq2_ff[2]);
         m3_ff    <= m2_ff;
         sum4_ff  <= part3_ff + sq3_ff;
         m4_ff    <= m3_ff;
         sum5_ff  <= sum4_ff;
         m5_ff    <= m4_ff;
      end
   end

   // ---------------- refinement lanes ----------------
   logic signed [mss_pkg::C_W-1:0] c4_all [mss_pkg::MAX_ITERATIONS];

   for (genvar k = 0; k < mss_pkg::MAX_ITERATIONS; k++) begin : g_lane
      localparam longint unsigned SCALE = 3 ** k;
      localparam longint unsigned DIV   = 3 ** (k + 1);
      localparam longint unsigned RECIP = (64'd1 << mss_pkg::RECIP_SHIFT) / DIV;
      localparam longint unsigned KOFS  = (mss_pkg::ONE + DIV - 1) / DIV;
      localparam longint unsigned KD    = KOFS * DIV;

      logic [PROD1_W-1:0]            prod [3];
      logic [FB:0]                   t [3];
      logic signed [FB+1:0]          a [3];
      logic [FB+1:0]                 aa [3];
      logic [FB+3:0]                 tri3 [3];
      logic signed [FB+3:0]          diff [3];
      logic [mss_pkg::LANE_W-1:0]    r_in [3];
      logic [mss_pkg::LANE_W-1:0]    r1_ff [3];

      // fold modulo two, then cross axis distance
      always_comb begin
         for (int i = 0; i < 3; i++) begin
            prod[i] = PROD1_W'(pos[i][FB:0]) * PROD1_W'(SCALE);
            t[i]    = prod[i][FB:0];
            a[i]    = $signed({1'b0, t[i]}) - $signed((FB+2)'(mss_pkg::ONE));
            aa[i]   = a[i][FB+1] ? (FB+2)'(-a[i]) : (FB+2)'(a[i]);
            tri3[i] = ({2'b00, aa[i]} << 1) + {2'b00, aa[i]};
            diff[i] = $signed((FB+4)'(mss_pkg::ONE)) - $signed(tri3[i]);
            r_in[i] = diff[i][FB+3] ? mss_pkg::LANE_W'(-diff[i])
                                    : mss_pkg::LANE_W'(diff[i]);
         end
      end

      // median of three, offset so the floor division works on a positive value
      logic [mss_pkg::LANE_W-1:0] lo01, hi01, hic, med, v_in, v2_ff, v3_ff;
      always_comb begin
         lo01 = (r1_ff[0] < r1_ff[1]) ? r1_ff[0] : r1_ff[1];
         hi01 = (r1_ff[0] < r1_ff[1]) ? r1_ff[1] : r1_ff[0];
         hic  = (hi01 < r1_ff[2]) ? hi01 : r1_ff[2];
         med  = (lo01 > hic) ? lo01 : hic;
         v_in = med + mss_pkg::LANE_W'(KD - mss_pkg::ONE);
      end

      // reciprocal multiply, quotient low by at most one
      logic [PROD3_W-1:0]         prod3;
      logic [mss_pkg::LANE_W-1:0] q3_ff, qd, rm, qf;
      logic signed [mss_pkg::C_W-1:0] c_in, c4_ff;
      always_comb begin
         prod3 = PROD3_W'(v2_ff) * PROD3_W'(RECIP);
         qd    = q3_ff * mss_pkg::LANE_W'(DIV);
         rm    = v3_ff - qd;
         qf    = (rm >= mss_pkg::LANE_W'(DIV)) ? q3_ff + 1'b1 : q3_ff;
         c_in  = $signed({1'b0, qf}) - $signed(mss_pkg::C_W'(KOFS));
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            r1_ff <= r_in;
            v2_ff <= v_in;
            q3_ff <= prod3[mss_pkg::RECIP_SHIFT +: mss_pkg::LANE_W];
            v3_ff <= v2_ff;
            c4_ff <= c_in;
         end
      end

      assign c4_all[k] = c4_ff;
   end

   // running maximum over the enabled lanes
   logic signed [mss_pkg::C_W-1:0] cmax_in, cmax5_ff;
   logic                           has5_ff;
   always_comb begin
      cmax_in = c4_all[0];
      for (int k = 1; k < mss_pkg::MAX_ITERATIONS; k++) begin
         if (((mss_pkg::COUNT_W+1)'(k) < {1'b0, count}) && (c4_all[k] > cmax_in)) begin
            cmax_in = c4_all[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cmax5_ff <= cmax_in;
         has5_ff  <= (count != '0);
      end
   end

   always_comb begin
      out_data.radicand  = sum5_ff;
      out_data.side.m    = m5_ff;
      out_data.side.cmax = cmax5_ff;
      out_data.side.has  = has5_ff;
   end
   assign out_valid = vld_ff[mss_pkg::FRONT_STAGES-1];

endmodule

/* rtl/mss_isqrt.sv */
// mss_isqrt: pipelined floor square root, one result bit per stage
// depends on mss_pkg; carries the side fields alongside
module mss_isqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  logic [mss_pkg::RAD_W-1:0]     radicand,
   input  mss_pkg::side_type             in_side,
   output logic                          out_valid,
   output logic [mss_pkg::ROOT_W-1:0]    root,
   output mss_pkg::side_type             out_side
);

   localparam int NS = mss_pkg::ROOT_W;

   logic [mss_pkg::REM_W-1:0]  rem_ff  [NS];
   logic [mss_pkg::ROOT_W-1:0] root_ff [NS];
   logic [mss_pkg::RAD_W-1:0]  rad_ff  [NS];
   mss_pkg::side_type          side_ff [NS];
   logic [NS-1:0]              vld_ff;

   for (genvar j = 0; j < NS; j++) begin : g_stage
      logic [mss_pkg::REM_W-1:0]  rem_p;
      logic [mss_pkg::ROOT_W-1:0] root_p;
      logic [mss_pkg::RAD_W-1:0]  rad_p;
      mss_pkg::side_type          side_p;
      logic                       vld_p;
      logic [mss_pkg::REM_W+1:0]  cur, trial;

      if (j == 0) begin : g_first
         assign rem_p  = '0;
         assign root_p = '0;
         assign rad_p  = radicand;
         assign side_p = in_side;
         assign vld_p  = in_valid;
      end else begin : g_next
         assign rem_p  = rem_ff[j-1];
         assign root_p = root_ff[j-1];
         assign rad_p  = rad_ff[j-1];
         assign side_p = side_ff[j-1];
         assign vld_p  = vld_ff[j-1];
      end

      assign cur   = {rem_p, rad_p[mss_pkg::RAD_W-1 -: 2]};
      assign trial = (mss_pkg::REM_W+2)'({root_p, 2'b01});

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (adv) begin
            vld_ff[j] <= vld_p;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            if (cur >= trial) begin
               rem_ff[j]  <= mss_pkg::REM_W'(cur - trial);
               root_ff[j] <= {root_p[mss_pkg::ROOT_W-2:0], 1'b1};
            end else begin
               rem_ff[j]  <= mss_pkg::REM_W'(cur);
               root_ff[j] <= {root_p[mss_pkg::ROOT_W-2:0], 1'b0};
            end
            rad_ff[j]  <= {rad_p[mss_pkg::RAD_W-3:0], 2'b00};
            side_ff[j] <= side_p;
         end
      end
   end

   assign out_valid = vld_ff[NS-1];
   assign root      = root_ff[NS-1];
   assign out_side  = side_ff[NS-1];

endmodule

/* rtl/menger_sponge_distance.sv */
// menger_sponge_distance: top level, input and output registers, final combine
// depends on mss_pkg, mss_front, mss_isqrt
//
//   channel   direction   ports                          handshake
//   req       in          req_pos_x/y/z                  req_valid / req_ready
//   rsp       out         rsp_distance                   rsp_valid / rsp_ready
//   csr       in          csr_wr_data (iteration count)  csr_wr_en
//
// one point enters per cycle while the output is not stalled; the path is input register, five front stages
// (box excess, squares, sum, lane divide, lane maximum), 32 root stages, output register
// the square root pipeline, one bit per stage, sets the latency
// reset clears all valid bits and sets the iteration count to 3
// a stalled output freezes the whole pipeline; nothing is lost or repeated
module menger_sponge_distance (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [mss_pkg::COORD_W-1:0] req_pos_x,
   input  logic signed [mss_pkg::COORD_W-1:0] req_pos_y,
   input  logic signed [mss_pkg::COORD_W-1:0] req_pos_z,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [mss_pkg::DIST_W-1:0]  rsp_distance,
   input  logic                               csr_wr_en,
   input  logic [mss_pkg::COUNT_W-1:0]        csr_wr_data
);

   localparam int DW = mss_pkg::D_W;
   localparam logic signed [DW-1:0] SAT_HI = DW'((64'sd1 <<< (mss_pkg::DIST_W - 1)) - 1);
   localparam logic signed [DW-1:0] SAT_LO = -SAT_HI - DW'(1);

   logic [mss_pkg::COUNT_W-1:0] count_ff;
   logic                        adv;
   logic                        vld0_ff;
   mss_pkg::coord_type          pos0_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= mss_pkg::COUNT_W'(mss_pkg::COUNT_RESET);
      end else if (csr_wr_en) begin
         count_ff <= csr_wr_data;
      end
   end

   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld0_ff <= 1'b0;
      end else if (adv) begin
         vld0_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pos0_ff[0] <= req_pos_x;
         pos0_ff[1] <= req_pos_y;
         pos0_ff[2] <= req_pos_z;
      end
   end

   logic               front_valid;
   mss_pkg::front_type front_data;

   mss_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (vld0_ff),
      .pos       (pos0_ff),
      .count     (count_ff),
      .out_valid (front_valid),
      .out_data  (front_data)
   );

   logic                        sq_valid;
   logic [mss_pkg::ROOT_W-1:0]  sq_root;
   mss_pkg::side_type           sq_side;

   mss_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (front_valid),
      .radicand  (front_data.radicand),
      .in_side   (front_data.side),
      .out_valid (sq_valid),
      .root      (sq_root),
      .out_side  (sq_side)
   );

   // box length plus inner maximum, then maximum with the lanes, then saturate
   logic signed [DW-1:0] box_d, cm_d, sel_d;
   logic signed [mss_pkg::DIST_W-1:0] dist_in;
   always_comb begin
      box_d = $signed({2'b00, sq_root}) + DW'(sq_side.m);
      cm_d  = DW'(sq_side.cmax);
      sel_d = (sq_side.has && (cm_d > box_d)) ? cm_d : box_d;
      if (sel_d > SAT_HI) begin
         dist_in = mss_pkg::DIST_W'(SAT_HI);
      end else if (sel_d < SAT_LO) begin
         dist_in = mss_pkg::DIST_W'(SAT_LO);
      end else begin
         dist_in = mss_pkg::DIST_W'(sel_d);
      end
   end

   logic                              rsp_valid_ff;
   logic signed [mss_pkg::DIST_W-1:0] rsp_distance_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_distance_ff <= dist_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_distance = rsp_distance_ff;

   a_accept_enters : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> vld0_ff)
      else $error("accepted transaction did not enter the pipeline");

   a_has_matches_count : assert property (@(posedge clock) disable iff (reset)
      front_valid |-> (front_data.side.has == (count_ff != '0)))
      else $error("lane flag does not match iteration count");

   a_inner_nonpositive : assert property (@(posedge clock) disable iff (reset)
      front_valid |-> (front_data.side.m[mss_pkg::M_W-1] || (front_data.side.m == '0)))
      else $error("inner maximum is positive");

   a_stall_freezes : assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(sq_valid))
      else $error("root pipeline moved during a stall");

endmodule
